/* rtl/hsc_pkg.sv */
// Shared constants, types and the arctangent table for the HSI shadow classifier.
`timescale 1ns / 1ps
package hsc_pkg;

  // Fixed-point fraction bits of V, S and H
  localparam int FRAC_BITS = 6;

  localparam int CH_W   = 8;
  localparam int SUM_W  = 10;               // r+g+b
  localparam int QUO_W  = FRAC_BITS + 8;    // S, V, theta (< 256 * 2^F)
  localparam int NUM_W  = FRAC_BITS + 18;   // 180 * 2^F * (sum - 3*min)
  localparam int H_W    = FRAC_BITS + 9;    // hue up to 360 deg
  localparam int HSV_W  = FRAC_BITS + 10;   // H + S + V
  localparam int DIFF_W = FRAC_BITS + 9;    // S - V, signed
  localparam int THR_W  = 7;
  localparam int COL_W  = 24;
  localparam int CFG_IDX_W = 2;

  // CORDIC vectoring datapath
  localparam int STEPS     = 24;
  localparam int ANG_BITS  = 24;
  localparam int XY_W      = 30;
  localparam int Z_W       = 34;
  localparam int SQRT3_Q16 = 113512;
  localparam int ROUND_SH  = ANG_BITS - FRAC_BITS;

  localparam logic [QUO_W-1:0] S_NUM_C   = QUO_W'(180 << FRAC_BITS);
  localparam logic [QUO_W-1:0] DEG180_F  = QUO_W'(180 << FRAC_BITS);
  localparam logic [H_W-1:0]   DEG360_F  = H_W'(360 << FRAC_BITS);
  localparam logic [31:0]      DEG180_Z  = 32'(64'd180 << ANG_BITS);
  localparam logic [Z_W-1:0]   DEG90_Z   = Z_W'(64'd90 << ANG_BITS);

  // V = floor(sum * 4 * 2^F / 17) through a reciprocal multiply
  localparam int V_K   = 16;
  localparam int V_M_W = FRAC_BITS + 14;
  localparam longint V_M_L = ((64'd1 << (V_K + FRAC_BITS + 2)) + 64'd16) / 17;
  localparam logic [V_M_W-1:0] V_M = V_M_W'(V_M_L);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_NODATA    = 2'd1
  } cfg_idx_e;

  // Per-item flags and intensity that ride alongside the CORDIC and divider
  typedef struct packed {
    logic             excl;   // no-data, white or black pixel
    logic             bgt;    // blue > green: mirror the hue
    logic             yzero;  // green == blue: hue from sign of x only
    logic             xneg;
    logic [QUO_W-1:0] v;
  } side_t;

  // atan(2^-i) in degrees, 24 fraction bits
  function automatic logic [31:0] atan_q24(input int i);
    logic [31:0] a;
    case (i)
      0:  a = 32'd754974720;
      1:  a = 32'd445687602;
      2:  a = 32'd235489088;
      3:  a = 32'd119537938;
      4:  a = 32'd60000934;
      5:  a = 32'd30029717;
      6:  a = 32'd15018523;
      7:  a = 32'd7509720;
      8:  a = 32'd3754917;
      9:  a = 32'd1877466;
      10: a = 32'd938734;
      11: a = 32'd469367;
      12: a = 32'd234684;
      13: a = 32'd117342;
      14: a = 32'd58671;
      15: a = 32'd29335;
      16: a = 32'd14668;
      17: a = 32'd7334;
      18: a = 32'd3667;
      19: a = 32'd1833;
      20: a = 32'd917;
      21: a = 32'd458;
      22: a = 32'd229;
      23: a = 32'd115;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

/* rtl/hsi_shadow_pixel_classifier.sv */
// Top level: HSI shadow-index classifier, one RGB pixel per cycle unless stalled.
`timescale 1ns / 1ps
// Takes one RGB pixel per clock and returns one shadow flag per pixel, in order.
// The pipeline is one setup stage, 24 CORDIC stages (the hue angle, with the
// saturation divider running beside it), then three stages for hue, the two
// threshold products and the compare. The whole pipeline advances together
// whenever the output register is empty or taken, so the sustained rate is
// one item per cycle while m_axis_tready is high. Configuration writes are
// always accepted and take effect at once; write them only while no item is
// in flight.
module hsi_shadow_pixel_classifier import hsc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [COL_W-1:0]     cfg_data_i,
  // pixel in
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [23:0]          s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
  // flag out
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata    // shadow[0], zero fill [7:1]
);

  logic             pipe_en;
  logic [THR_W-1:0] thr_q;
  logic [COL_W-1:0] nodata_q;

  // configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= THR_W'(35);
      nodata_q <= COL_W'(3285538);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_THRESHOLD) thr_q    <= cfg_data_i[THR_W-1:0];
      if (cfg_index_i == CFG_NODATA)    nodata_q <= cfg_data_i;
    end
  end

  assign pipe_en       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = pipe_en;

  // ---------------- setup stage ----------------
  logic [CH_W-1:0]          r, g, b, mn, gb_abs;
  logic [SUM_W-1:0]         sum, smin;
  logic signed [10:0]       dx;
  logic signed [XY_W-1:0]   x0, y0;
  logic [24:0]              yprod;
  logic [SUM_W+V_M_W-1:0]   vprod;
  side_t                    side_d;
  logic signed [XY_W-1:0]   x1_d, y1_d;
  logic signed [Z_W-1:0]    z1_d;

  assign r = s_axis_tdata[7:0];
  assign g = s_axis_tdata[15:8];
  assign b = s_axis_tdata[23:16];

  always_comb begin
    mn     = (r < g) ? r : g;
    if (b < mn) mn = b;
    sum    = SUM_W'(r) + SUM_W'(g) + SUM_W'(b);
    smin   = sum - (SUM_W'(mn) + SUM_W'(mn) + SUM_W'(mn));
    gb_abs = (g > b) ? (g - b) : (b - g);
    dx     = signed'({2'b00, r, 1'b0}) - signed'({3'b000, g}) - signed'({3'b000, b});
    x0     = signed'({{(XY_W-27){dx[10]}}, dx, 16'b0});
    yprod  = 25'(gb_abs) * 25'(SQRT3_Q16);
    y0     = signed'(XY_W'(yprod));
    vprod  = (SUM_W+V_M_W)'(sum) * (SUM_W+V_M_W)'(V_M);

    // no-data colour is packed red high, blue low
    side_d.excl  = ({r, g, b} == nodata_q) || (s_axis_tdata == 24'hFFFFFF)
                   || (sum == '0);
    side_d.bgt   = (b > g);
    side_d.yzero = (g == b);
    side_d.xneg  = dx[10];
    side_d.v     = vprod[V_K +: QUO_W];

    // left half-plane: pre-rotate by 90 degrees
    if (dx[10]) begin
      x1_d = y0;
      y1_d = -x0;
      z1_d = DEG90_Z;
    end else begin
      x1_d = x0;
      y1_d = y0;
      z1_d = '0;
    end
  end

  logic                   vld1_q;
  side_t                  side1_q;
  logic signed [XY_W-1:0] x1_q, y1_q;
  logic signed [Z_W-1:0]  z1_q;
  logic [NUM_W-1:0]       num1_q;
  logic [SUM_W-1:0]       den1_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      side1_q <= side_d;
      x1_q    <= x1_d;
      y1_q    <= y1_d;
      z1_q    <= z1_d;
      num1_q  <= NUM_W'(smin) * NUM_W'(S_NUM_C);
      den1_q  <= sum;
    end
  end

  // ---------------- angle and saturation ----------------
  logic signed [Z_W-1:0] z_c;
  logic [QUO_W-1:0]      s_c;

  hsc_cordic u_cordic (
    .clk_i (clk_i),
    .en_i  (pipe_en),
    .x_i   (x1_q),
    .y_i   (y1_q),
    .z_i   (z1_q),
    .z_o   (z_c)
  );

  hsc_div u_div (
    .clk_i (clk_i),
    .en_i  (pipe_en),
    .num_i (num1_q),
    .den_i (den1_q),
    .quo_o (s_c)
  );

  side_t            side_q [STEPS];
  logic [STEPS-1:0] vldc_q;

  for (genvar k = 0; k < STEPS; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (pipe_en) side_q[k] <= (k == 0) ? side1_q : side_q[(k == 0) ? 0 : k-1];
    end
  end

  // ---------------- hue and sums ----------------
  side_t            sc;
  logic [31:0]      zc;
  logic [32:0]      zr;
  logic [QUO_W-1:0] theta;
  logic [H_W-1:0]   h;

  assign sc = side_q[STEPS-1];

  always_comb begin
    if (z_c < 0)                              zc = '0;
    else if (z_c > signed'(Z_W'(DEG180_Z)))   zc = DEG180_Z;
    else                                      zc = z_c[31:0];
    zr = 33'(zc) + 33'(64'd1 << (ROUND_SH - 1));
    if (sc.yzero) theta = sc.xneg ? DEG180_F : '0;
    else          theta = zr[ROUND_SH +: QUO_W];
    h = sc.bgt ? (DEG360_F - H_W'(theta)) : H_W'(theta);
  end

  logic                     vldp1_q, exclp1_q;
  logic signed [DIFF_W-1:0] diff_q;
  logic [HSV_W-1:0]         hsv_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      exclp1_q <= sc.excl;
      diff_q   <= signed'(DIFF_W'(s_c)) - signed'(DIFF_W'(sc.v));
      hsv_q    <= HSV_W'(h) + HSV_W'(s_c) + HSV_W'(sc.v);
    end
  end

  // ---------------- threshold products ----------------
  logic                       vldp2_q, exclp2_q;
  logic signed [DIFF_W+6:0]   lhs_q;
  logic [HSV_W+6:0]           rhs_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      exclp2_q <= exclp1_q;
      lhs_q    <= (DIFF_W+7)'(diff_q) * signed'((DIFF_W+7)'(100));
      rhs_q    <= (HSV_W+7)'(hsv_q) * (HSV_W+7)'(thr_q);
    end
  end

  // ---------------- compare and output register ----------------
  logic shadow_q;
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      shadow_q <= !exclp2_q &&
                  (signed'((HSV_W+8)'(lhs_q)) > signed'({1'b0, rhs_q}));
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q        <= 1'b0;
      vldc_q        <= '0;
      vldp1_q       <= 1'b0;
      vldp2_q       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (pipe_en) begin
      vld1_q        <= s_axis_tvalid;
      vldc_q        <= {vldc_q[STEPS-2:0], vld1_q};
      vldp1_q       <= vldc_q[STEPS-1];
      vldp2_q       <= vldp1_q;
      m_axis_tvalid <= vldp2_q;
    end
  end

  assign m_axis_tdata = {7'b0, shadow_q};

  // ---------------- assertions ----------------
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> $stable(vldc_q) && $stable(vldp1_q) && $stable(vldp2_q))
    else $error("pipeline moved during a stall");

  a_sat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vldc_q[STEPS-1] && !sc.excl |-> s_c <= S_NUM_C)
    else $error("saturation quotient out of range");

  a_theta_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vldc_q[STEPS-1] |-> theta <= DEG180_F)
    else $error("hue angle above 180 degrees");

endmodule

/* rtl/hsc_cordic.sv */
// Pipelined CORDIC vectoring unit, one micro-rotation per register stage.
`timescale 1ns / 1ps
module hsc_cordic import hsc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [XY_W-1:0] x_i,
  input  logic signed [XY_W-1:0] y_i,
  input  logic signed [Z_W-1:0]  z_i,
  output logic signed [Z_W-1:0]  z_o
);

  logic signed [XY_W-1:0] x_q [STEPS];
  logic signed [XY_W-1:0] y_q [STEPS];
  logic signed [Z_W-1:0]  z_q [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [XY_W-1:0] xin, yin, xs, ys;
    logic signed [Z_W-1:0]  zin, ang;

    if (i == 0) begin : g_first
      assign xin = x_i;
      assign yin = y_i;
      assign zin = z_i;
    end else begin : g_next
      assign xin = x_q[i-1];
      assign yin = y_q[i-1];
      assign zin = z_q[i-1];
    end

    // arithmetic shift floors negative values
    assign xs  = xin >>> i;
    assign ys  = yin >>> i;
    assign ang = signed'({{(Z_W-32){1'b0}}, atan_q24(i)});

    // rotate toward the x axis, accumulate the angle
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (yin > 0) begin
          x_q[i] <= xin + ys;
          y_q[i] <= yin - xs;
          z_q[i] <= zin + ang;
        end else begin
          x_q[i] <= xin - ys;
          y_q[i] <= yin + xs;
          z_q[i] <= zin - ang;
        end
      end
    end
  end

  assign z_o = z_q[STEPS-1];

endmodule

/* rtl/hsc_div.sv */
// Pipelined restoring divider, one quotient bit per stage, padded to the CORDIC depth.
`timescale 1ns / 1ps
module hsc_div import hsc_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [SUM_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o
);

  logic [NUM_W-1:0] rem_q [STEPS];
  logic [SUM_W-1:0] den_q [STEPS];
  logic [QUO_W-1:0] quo_q [STEPS];

  for (genvar j = 0; j < STEPS; j++) begin : g_stage
    logic [NUM_W-1:0] rin;
    logic [SUM_W-1:0] din;
    logic [QUO_W-1:0] qin;

    if (j == 0) begin : g_first
      assign rin = num_i;
      assign din = den_i;
      assign qin = '0;
    end else begin : g_next
      assign rin = rem_q[j-1];
      assign din = den_q[j-1];
      assign qin = quo_q[j-1];
    end

    if (j < QUO_W) begin : g_bit
      localparam int K = QUO_W - 1 - j;
      logic [NUM_W-1:0] dsh;
      logic             ge;
      logic [QUO_W-1:0] qn;

      // trial subtract of the divisor aligned to quotient bit K
      assign dsh = NUM_W'(din) << K;
      assign ge  = (rin >= dsh);
      always_comb begin
        qn    = qin;
        qn[K] = ge;
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j] <= ge ? (rin - dsh) : rin;
          den_q[j] <= din;
          quo_q[j] <= qn;
        end
      end
    end else begin : g_pad
      // quotient done: carry it to line up with the angle
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j] <= rin;
          den_q[j] <= din;
          quo_q[j] <= qin;
        end
      end
    end
  end

  assign quo_o = quo_q[STEPS-1];

endmodule
